[src/swod_pkg.sv]
package swod_pkg;

   // Sample format
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = SAMPLE_BITS - 1;

   // Drive table
   localparam int NUM_DRIVE_LEVELS = 10;
   localparam int ROM_DEPTH        = 16;
   localparam int DRIVE_BITS       = 4;
   localparam int K_BITS           = 23;
   localparam int K_FRAC_BITS      = 8;

   // Datapath widths
   localparam int PROD_BITS = K_BITS + SAMPLE_BITS;
   localparam int DEN_BITS  = PROD_BITS + 1;
   localparam int REM_BITS  = DEN_BITS + 1;
   localparam int DIV_STEPS = SAMPLE_BITS;

   // Pipeline stage map
   localparam int ST_MAG     = 0;
   localparam int ST_PROD    = 1;
   localparam int ST_DIVIN   = 2;
   localparam int DIV_FIRST  = 3;
   localparam int ST_OUT     = DIV_FIRST + DIV_STEPS;
   localparam int NUM_STAGES = ST_OUT + 1;

   localparam logic [DEN_BITS-1:0]  DEN_ONE = DEN_BITS'(1) << (K_FRAC_BITS + FRAC_BITS);
   localparam logic [DIV_STEPS-1:0] Q_HALF  = DIV_STEPS'(1) << FRAC_BITS;

   // Gain k in unsigned Q15.8 per drive level; spare slots repeat level 0
   localparam logic [K_BITS-1:0] GAIN_ROM [ROM_DEPTH] = '{
      23'd105, 23'd242, 23'd443, 23'd753, 23'd1269, 23'd2221, 23'd4278,
      23'd10158, 23'd41909, 23'd4233106,
      23'd105, 23'd105, 23'd105, 23'd105, 23'd105, 23'd105
   };

   typedef logic signed [SAMPLE_BITS-1:0] swod_sample_type;
   typedef logic [K_BITS-1:0]             swod_gain_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } swod_ctrl_type;

   // Out-of-range drive levels fall back to level 0
   function automatic swod_gain_type gain_lookup(input logic [DRIVE_BITS-1:0] idx);
      swod_gain_type g;
      if (int'(idx) < NUM_DRIVE_LEVELS) begin
         g = GAIN_ROM[idx];
      end else begin
         g = GAIN_ROM[0];
      end
      return g;
   endfunction

endpackage

[src/swod_shaper.sv]
module swod_shaper (
   input  logic                    clock,
   input  swod_pkg::swod_ctrl_type ctrl,
   input  swod_pkg::swod_gain_type gain,
   input  swod_pkg::swod_sample_type sample,
   output swod_pkg::swod_sample_type shaped
);
   import swod_pkg::*;

   logic [SAMPLE_BITS-1:0] mag_in;
   logic [SAMPLE_BITS-1:0] mag_ff;
   logic [SAMPLE_BITS-1:0] mag_prod_ff;
   logic                   neg_ff [NUM_STAGES-1];
   logic [PROD_BITS-1:0]   prod_in;
   logic [PROD_BITS-1:0]   prod_ff;
   logic [DEN_BITS-1:0]    num_in;
   logic [DEN_BITS-1:0]    den_in;
   logic [DEN_BITS-1:0]    rem_ff [DIV_STEPS];
   logic [DEN_BITS-1:0]    den_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0]   quo_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0]   quo_sat;
   swod_sample_type        shaped_in;
   swod_sample_type        shaped_ff;

   // Stage 0: split sign and magnitude
   assign mag_in = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'($unsigned(~sample) + 1'b1)
                                         : SAMPLE_BITS'($unsigned(sample));

   always_ff @(posedge clock) begin
      if (ctrl.load[ST_MAG]) begin
         mag_ff <= mag_in;
      end
   end

   // Carry the sign along to the output stage
   always_ff @(posedge clock) begin
      if (ctrl.load[ST_MAG]) begin
         neg_ff[0] <= sample[SAMPLE_BITS-1];
      end
      for (int s = 1; s < NUM_STAGES - 1; s++) begin
         if (ctrl.load[s]) begin
            neg_ff[s] <= neg_ff[s-1];
         end
      end
   end

   // Stage 1: k * |x|
   assign prod_in = PROD_BITS'(gain) * PROD_BITS'(mag_ff);

   always_ff @(posedge clock) begin
      if (ctrl.load[ST_PROD]) begin
         prod_ff     <= prod_in;
         mag_prod_ff <= mag_ff;
      end
   end

   // Stage 2: numerator (1+k)|x| and denominator 1 + k|x|
   assign num_in = (DEN_BITS'(mag_prod_ff) << K_FRAC_BITS) + DEN_BITS'(prod_ff);
   assign den_in = DEN_ONE + DEN_BITS'(prod_ff);

   always_ff @(posedge clock) begin
      if (ctrl.load[ST_DIVIN]) begin
         rem_ff[0] <= num_in;
         den_ff[0] <= den_in;
      end
   end

   // Restoring divider, one quotient bit per stage
   for (genvar d = 0; d < DIV_STEPS; d++) begin : g_step
      logic [REM_BITS-1:0]  trial;
      logic [DIV_STEPS-1:0] quo_prev;
      logic                 take;
      logic [DEN_BITS-1:0]  rem_in;
      logic [DIV_STEPS-1:0] quo_in;

      if (d == 0) begin : g_head
         assign trial    = {1'b0, rem_ff[0]};
         assign quo_prev = '0;
      end else begin : g_body
         assign trial    = {rem_ff[d], 1'b0};
         assign quo_prev = quo_ff[d-1];
      end

      assign take   = trial >= {1'b0, den_ff[d]};
      assign rem_in = take ? DEN_BITS'(trial - {1'b0, den_ff[d]}) : DEN_BITS'(trial);
      assign quo_in = {quo_prev[DIV_STEPS-2:0], take};

      always_ff @(posedge clock) begin
         if (ctrl.load[DIV_FIRST + d]) begin
            quo_ff[d] <= quo_in;
         end
      end

      if (d < DIV_STEPS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (ctrl.load[DIV_FIRST + d]) begin
               rem_ff[d+1] <= rem_in;
               den_ff[d+1] <= den_ff[d];
            end
         end
      end
   end

   // Output stage: saturate and restore the sign
   always_comb begin
      if (neg_ff[NUM_STAGES-2]) begin
         quo_sat   = (quo_ff[DIV_STEPS-1] > Q_HALF) ? Q_HALF : quo_ff[DIV_STEPS-1];
         shaped_in = swod_sample_type'(SAMPLE_BITS'(~quo_sat + 1'b1));
      end else begin
         quo_sat   = (quo_ff[DIV_STEPS-1] > Q_HALF - 1'b1) ? DIV_STEPS'(Q_HALF - 1'b1)
                                                           : quo_ff[DIV_STEPS-1];
         shaped_in = swod_sample_type'(SAMPLE_BITS'(quo_sat));
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[ST_OUT]) begin
         shaped_ff <= shaped_in;
      end
   end

   assign shaped = shaped_ff;

endmodule

[src/stereo_waveshaper_overdrive.sv]
// Channel   Handshake              Beat contents
// -------   --------------------   ----------------------------------------------
// req       req_valid/req_ready    req_left_sample, req_right_sample, req_last_pair
// rsp       rsp_valid/rsp_ready    rsp_left_shaped, rsp_right_shaped, rsp_last_pair_out
// csr       csr_valid/csr_ready    csr_drive_index (always ready)
//
// One stereo pair is accepted per cycle while the output does not stall; the stages are:
// magnitude, k*|x| multiply, numerator/denominator, 16 divider stages (one
// quotient bit each), then saturation into the output register.
// Reset clears every stage valid bit and selects drive level 0.
// Empty stages collapse under a stall: req_ready stays high while any stage
// from the input to the output register is free, so nothing is dropped.
module stereo_waveshaper_overdrive (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  swod_pkg::swod_sample_type             req_left_sample,
   input  swod_pkg::swod_sample_type             req_right_sample,
   input  logic                                  req_last_pair,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output swod_pkg::swod_sample_type             rsp_left_shaped,
   output swod_pkg::swod_sample_type             rsp_right_shaped,
   output logic                                  rsp_last_pair_out,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [swod_pkg::DRIVE_BITS-1:0]       csr_drive_index
);
   import swod_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] last_ff;
   logic [NUM_STAGES-1:0] load;
   swod_ctrl_type         ctrl;
   swod_gain_type         gain_ff;
   swod_gain_type         gain_in;

   // Drive register holds the looked-up gain
   assign csr_ready = 1'b1;
   assign gain_in   = gain_lookup(csr_drive_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_ROM[0];
      end else if (csr_valid && csr_ready) begin
         gain_ff <= gain_in;
      end
   end

   // A stage loads when it is empty or the stage after it loads
   always_comb begin
      load[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;
      for (int s = NUM_STAGES - 2; s >= 0; s--) begin
         load[s] = !valid_ff[s] || load[s+1];
      end
   end

   assign ctrl.load = load;
   assign req_ready = load[0];

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (load[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int s = 1; s < NUM_STAGES; s++) begin
            if (load[s]) begin
               valid_ff[s] <= valid_ff[s-1];
            end
         end
      end
   end

   // Carry the last flag alongside
   always_ff @(posedge clock) begin
      if (load[0]) begin
         last_ff[0] <= req_last_pair;
      end
      for (int s = 1; s < NUM_STAGES; s++) begin
         if (load[s]) begin
            last_ff[s] <= last_ff[s-1];
         end
      end
   end

   swod_shaper u_left (
      .clock  (clock),
      .ctrl   (ctrl),
      .gain   (gain_ff),
      .sample (req_left_sample),
      .shaped (rsp_left_shaped)
   );

   swod_shaper u_right (
      .clock  (clock),
      .ctrl   (ctrl),
      .gain   (gain_ff),
      .sample (req_right_sample),
      .shaped (rsp_right_shaped)
   );

   assign rsp_valid         = valid_ff[NUM_STAGES-1];
   assign rsp_last_pair_out = last_ff[NUM_STAGES-1];

endmodule

[src/swod_checker.sv]
module swod_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input swod_pkg::swod_sample_type       rsp_left_shaped,
   input swod_pkg::swod_sample_type       rsp_right_shaped,
   input logic                            rsp_last_pair_out
);
   import swod_pkg::*;

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_left_shaped) && $stable(rsp_right_shaped)
                                  && $stable(rsp_last_pair_out))
      else $error("rsp payload changed while stalled");

   // Pipeline empties on reset and is open for input
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   // A free output register or a taken result keeps the input open
   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("input stalled with a free pipeline");

endmodule

bind stereo_waveshaper_overdrive swod_checker u_swod_checker (.*);
